// File: hdl/atrf_pkg.sv
// ----------------------------------------------------------------------------
// Alarm transition rate filter package
// Field widths, register indexes, reset values and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package atrf_pkg;

  // Fixed field widths
  localparam int SRC_W       = 8;
  localparam int STATUS_W    = 8;
  localparam int LEVEL_W     = 3;
  localparam int PERIOD_W    = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_PERIOD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_CODE   = 1'd1;

  // Configuration reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000;
  localparam logic [LEVEL_W-1:0]  ALARM_RESET  = 3'd0;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input item and read its table entry
    logic sweep;   // write one table entry invalid and advance the sweep
    logic commit;  // write back the entry and load the result register
  } atrf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sweep_last;  // sweep is at the final table entry
  } atrf_stat_t;

endpackage

// File: hdl/atrf_ctrl.sv
// ----------------------------------------------------------------------------
// Alarm transition rate filter controller
// Sequences table sweeps, entry read, evaluation and the result transfer.
// ----------------------------------------------------------------------------
module atrf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  output logic                out_valid,
  input  logic                out_ready,
  output atrf_pkg::atrf_cmd_t cmd,
  input  atrf_pkg::atrf_stat_t stat
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_CLEAR,
    ST_EVAL
  } state_t;

  state_t state;
  logic   out_free;

  // Decode commands from state
  always_comb begin
    in_ready   = (state == ST_IDLE);
    out_free   = !out_valid || out_ready;
    cmd.load   = in_ready && in_valid;
    cmd.sweep  = (state == ST_SWEEP) || (state == ST_CLEAR);
    cmd.commit = (state == ST_EVAL) && out_free;
  end

  // Advance state and hold the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_SWEEP: begin
          if (stat.sweep_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= func ? ST_CLEAR : ST_EVAL;
          end
        end
        ST_CLEAR: begin
          if (stat.sweep_last) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (out_free) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/atrf_datapath.sv
// ----------------------------------------------------------------------------
// Alarm transition rate filter datapath
// Source table memory, configuration registers, schedule arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module atrf_datapath #(
  parameter int SOURCES   = 256,
  parameter int TIME_BITS = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [atrf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [atrf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                func,
  input  logic [atrf_pkg::SRC_W-1:0]          source_id,
  input  logic [atrf_pkg::STATUS_W-1:0]       event_status,
  input  logic [atrf_pkg::LEVEL_W-1:0]        alarm_in,
  input  logic [TIME_BITS-1:0]                event_time,
  output logic                                pass,
  input  atrf_pkg::atrf_cmd_t                 cmd,
  output atrf_pkg::atrf_stat_t                stat
);

  localparam int IDX_W   = $clog2(SOURCES);
  localparam int WIDE_W  = (TIME_BITS > atrf_pkg::PERIOD_W) ? TIME_BITS : atrf_pkg::PERIOD_W;
  localparam int NXT_W   = WIDE_W + 1;
  localparam int SUM_W   = NXT_W + 1;
  localparam int WORD_W  = 1 + atrf_pkg::LEVEL_W + NXT_W;
  localparam int SRC_N   = 1 << atrf_pkg::SRC_W;

  // Source id to table index, reduced modulo the table depth
  logic [IDX_W-1:0] src_map [SRC_N];
  for (genvar gi = 0; gi < SRC_N; gi++) begin : g_src_map
    assign src_map[gi] = IDX_W'(gi % SOURCES);
  end

  // Configuration registers
  logic [atrf_pkg::PERIOD_W-1:0] write_period;
  logic [atrf_pkg::LEVEL_W-1:0]  alarm_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_period <= atrf_pkg::PERIOD_RESET;
      alarm_code   <= atrf_pkg::ALARM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        atrf_pkg::CFG_WRITE_PERIOD: write_period <= cfg_data;
        atrf_pkg::CFG_ALARM_CODE:   alarm_code   <= cfg_data[atrf_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item
  logic                          item_func;
  logic [IDX_W-1:0]              item_idx;
  logic [atrf_pkg::STATUS_W-1:0] item_status;
  logic [atrf_pkg::LEVEL_W-1:0]  item_level;
  logic [TIME_BITS-1:0]          item_time;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_func   <= func;
      item_idx    <= src_map[source_id];
      item_status <= event_status;
      item_level  <= alarm_in;
      item_time   <= event_time;
    end
  end

  // Sweep counter for clearing the table
  logic [IDX_W-1:0] sweep_cnt;
  logic             sweep_last;

  assign sweep_last      = (sweep_cnt == IDX_W'(SOURCES - 1));
  assign stat.sweep_last = sweep_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_last ? '0 : sweep_cnt + IDX_W'(1);
    end
  end

  // Source table: valid bit, last level, next permitted time
  logic [WORD_W-1:0] table_mem [SOURCES];
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] wr_word;
  logic [IDX_W-1:0]  wr_addr;
  logic              mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[wr_addr] <= wr_word;
    end
    if (cmd.load) begin
      rd_word <= table_mem[src_map[source_id]];
    end
  end

  // Evaluate the entry against the item
  logic                         e_valid;
  logic [atrf_pkg::LEVEL_W-1:0] e_level;
  logic [NXT_W-1:0]             e_next;
  logic [SUM_W-1:0]             t_wide;
  logic [SUM_W-1:0]             s_sched;
  logic [SUM_W-1:0]             s_event;
  logic                         permitted;
  logic                         late;
  logic [NXT_W-1:0]             new_next;
  logic                         accepted;
  logic                         do_write;
  logic                         pass_calc;

  always_comb begin
    e_valid   = rd_word[WORD_W-1];
    e_level   = rd_word[NXT_W +: atrf_pkg::LEVEL_W];
    e_next    = rd_word[NXT_W-1:0];
    t_wide    = SUM_W'(item_time);
    s_sched   = SUM_W'(e_next) + SUM_W'(write_period);
    s_event   = t_wide + SUM_W'(write_period);
    permitted = (t_wide >= SUM_W'(e_next));
    late      = (t_wide >= s_sched);
    // Restart at the event time when a full period late, else advance
    if (!e_valid || late) begin
      new_next = s_event[NXT_W-1:0];
    end else begin
      new_next = s_sched[NXT_W-1:0];
    end
    accepted = !item_func && (item_status == '0);
    do_write = accepted && (!e_valid || permitted);
    // Pass on a first sighting at alarm, or on a qualifying level change
    if (!accepted) begin
      pass_calc = 1'b0;
    end else if (!e_valid) begin
      pass_calc = (item_level == alarm_code);
    end else if (permitted && (item_level != e_level)) begin
      pass_calc = (item_level == alarm_code) ||
                  ((item_level > e_level) && (e_level == alarm_code));
    end else begin
      pass_calc = 1'b0;
    end
  end

  // Table write: sweep clears, commit writes back
  always_comb begin
    mem_we  = cmd.sweep || (cmd.commit && do_write);
    wr_addr = cmd.sweep ? sweep_cnt : item_idx;
    wr_word = cmd.sweep ? '0 : {1'b1, item_level, new_next};
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pass <= pass_calc;
    end
  end

endmodule

// File: hdl/alarm_transition_rate_filter_core.sv
// ----------------------------------------------------------------------------
// Alarm transition rate filter core
// Per-source alarm event filter with rate limiting and level transition
// checks, built from a controller and a table datapath.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  -------   ---------------------   -----------------------------------------
//  input     in_valid / in_ready     func, source_id, event_status, alarm_in,
//                                    event_time
//  result    out_valid / out_ready   pass
//  config    cfg_we                  cfg_index, cfg_data
//
// An event reads its table entry from the table memory, then is evaluated and
// its entry is written back.
// A clear command is taken, then the table memory is cleared by a
// one-entry-a-cycle sweep, then the result is posted.
// After reset the whole table is swept with in_ready low.
// A new item is taken while a result waits; it holds in evaluation until the
// result register is free.
// ----------------------------------------------------------------------------
module alarm_transition_rate_filter_core #(
  parameter int SOURCES   = 256,
  parameter int TIME_BITS = 48
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [atrf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [atrf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             func,
  input  logic [atrf_pkg::SRC_W-1:0]       source_id,
  input  logic [atrf_pkg::STATUS_W-1:0]    event_status,
  input  logic [atrf_pkg::LEVEL_W-1:0]     alarm_in,
  input  logic [TIME_BITS-1:0]             event_time,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             pass
);

  atrf_pkg::atrf_cmd_t  cmd;
  atrf_pkg::atrf_stat_t stat;

  // Sequence the work
  atrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Hold the table and compute the result
  atrf_datapath #(
    .SOURCES   (SOURCES),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .source_id    (source_id),
    .event_status (event_status),
    .alarm_in     (alarm_in),
    .event_time   (event_time),
    .pass         (pass),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

// File: bench/tb_alarm_transition_rate_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm transition rate filter core testbench
// Sends directed and random alarm events through the valid/ready input
// channel with random idle cycles on both sides, predicts each pass flag with
// a per-source table kept in the bench, and compares every result in order.
// ----------------------------------------------------------------------------
module tb_alarm_transition_rate_filter_core;

  localparam int SOURCES     = 256;
  localparam int TIME_BITS   = 48;
  localparam int SRC_W       = atrf_pkg::SRC_W;
  localparam int STATUS_W    = atrf_pkg::STATUS_W;
  localparam int LEVEL_W     = atrf_pkg::LEVEL_W;
  localparam int PERIOD_W    = atrf_pkg::PERIOD_W;
  localparam int CFG_INDEX_W = atrf_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = atrf_pkg::CFG_DATA_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic {
    FUNC_EXAMINE = 1'b0,
    FUNC_CLEAR   = 1'b1
  } func_e;

  typedef struct {
    func_e                 fn;
    logic [SRC_W-1:0]      src;
    logic [STATUS_W-1:0]   status;
    logic [LEVEL_W-1:0]    level;
    logic [TIME_BITS-1:0]  stamp;
  } alarm_event_t;

  typedef struct {
    bit          fwd;
    int unsigned seq;
  } verdict_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic                   func;
  logic [SRC_W-1:0]       source_id;
  logic [STATUS_W-1:0]    event_status;
  logic [LEVEL_W-1:0]     alarm_in;
  logic [TIME_BITS-1:0]   event_time;
  logic                   out_valid;
  logic                   out_ready;
  logic                   pass;

  // Bench copy of the filter table and registers
  bit                   src_open [SOURCES];
  logic [LEVEL_W-1:0]   src_level[SOURCES];
  logic [TIME_BITS:0]   src_due  [SOURCES];
  logic [PERIOD_W-1:0]  period_cfg = atrf_pkg::PERIOD_RESET;
  logic [LEVEL_W-1:0]   alarm_cfg  = atrf_pkg::ALARM_RESET;

  verdict_t    verdict_q[$];
  int unsigned sent_count;
  int unsigned mismatch_count;
  bit          no_idle;

  alarm_transition_rate_filter_core #(
    .SOURCES  (SOURCES),
    .TIME_BITS(TIME_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .source_id   (source_id),
    .event_status(event_status),
    .alarm_in    (alarm_in),
    .event_time  (event_time),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pass        (pass)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Predict the pass flag of one event and update the table copy
  function automatic bit filter_event(alarm_event_t ev);
    logic [TIME_BITS:0]   next_due;
    logic [TIME_BITS+1:0] late_mark;
    int                   slot;
    bit                   fwd;
    fwd = 1'b0;
    if (ev.fn == FUNC_CLEAR) begin
      foreach (src_open[i]) src_open[i] = 1'b0;
      return 1'b0;
    end
    if (ev.status != '0) return 1'b0;
    slot = int'(ev.src) % SOURCES;
    // open the entry on first sight
    if (!src_open[slot]) begin
      src_open[slot]  = 1'b1;
      src_level[slot] = ev.level;
      src_due[slot]   = {1'b0, ev.stamp} + (TIME_BITS+1)'(period_cfg);
      return ev.level == alarm_cfg;
    end
    // drop early events untouched
    if ({1'b0, ev.stamp} >= src_due[slot]) begin
      late_mark = {1'b0, src_due[slot]} + (TIME_BITS+2)'(period_cfg);
      next_due  = src_due[slot];
      if ({2'b00, ev.stamp} >= late_mark) next_due = {1'b0, ev.stamp};
      src_due[slot] = next_due + (TIME_BITS+1)'(period_cfg);
      if (ev.level != src_level[slot]) begin
        fwd = (ev.level == alarm_cfg) ||
              (ev.level > src_level[slot] && src_level[slot] == alarm_cfg);
        src_level[slot] = ev.level;
      end
    end
    return fwd;
  endfunction

  // Present one event, hold it until the transfer, then record its verdict
  task automatic send_event(input func_e fn, input logic [SRC_W-1:0] src,
                            input logic [STATUS_W-1:0] status,
                            input logic [LEVEL_W-1:0] level,
                            input logic [TIME_BITS-1:0] stamp);
    alarm_event_t ev;
    verdict_t     entry;
    int           gap;
    ev  = '{fn, src, status, level, stamp};
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= fn;
    source_id    <= src;
    event_status <= status;
    alarm_in     <= level;
    event_time   <= stamp;
    do @(posedge clk); while (!in_ready);
    entry.fwd = filter_event(ev);
    entry.seq = sent_count;
    verdict_q.insert(verdict_q.size(), entry);
    sent_count++;
  endtask

  task automatic send_examine(input logic [SRC_W-1:0] src,
                              input logic [STATUS_W-1:0] status,
                              input logic [LEVEL_W-1:0] level,
                              input logic [TIME_BITS-1:0] stamp);
    send_event(FUNC_EXAMINE, src, status, level, stamp);
  endtask

  // Clear with random filler on the other fields
  task automatic send_clear();
    send_event(FUNC_CLEAR, SRC_W'($urandom_range(0, 255)),
               STATUS_W'($urandom_range(0, 255)),
               LEVEL_W'($urandom_range(0, 7)), TIME_BITS'({$urandom, $urandom}));
  endtask

  // Drop valid and wait until every verdict has been matched
  task automatic settle_results();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      atrf_pkg::CFG_WRITE_PERIOD: period_cfg = data[PERIOD_W-1:0];
      atrf_pkg::CFG_ALARM_CODE:   alarm_cfg  = data[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  // Reset registers: first sight, early drop, transitions, restart, reject
  task automatic test_reset_defaults();
    send_examine(8'd0,   8'h00, 3'd0, 48'd0);
    send_examine(8'd0,   8'h00, 3'd5, 48'd999);
    send_examine(8'd0,   8'h00, 3'd5, 48'd1000);
    send_examine(8'd0,   8'h00, 3'd5, 48'd2000);
    send_examine(8'd0,   8'h00, 3'd0, 48'd3500);
    send_examine(8'd0,   8'h00, 3'd0, 48'd6000);
    send_examine(8'd255, 8'hFF, 3'd7, TIME_MAX);
    send_examine(8'd255, 8'h01, 3'd0, 48'd0);
    send_examine(8'd255, 8'h00, 3'd7, TIME_MAX);
    send_examine(8'd255, 8'h80, 3'd0, TIME_MAX);
    send_examine(8'd255, 8'h00, 3'd0, TIME_MAX);
    send_examine(8'd170, 8'h00, 3'd3, 48'h5555_5555_5555);
    send_examine(8'd85,  8'h00, 3'd0, 48'hAAAA_AAAA_AAAA);
    send_examine(8'd170, 8'h00, 3'd2, 48'h5555_5555_5555 + 48'd1000);
    send_clear();
    send_examine(8'd0,   8'h00, 3'd4, 48'd10);
    send_examine(8'd255, 8'h00, 3'd0, 48'd5);
  endtask

  // Period and alarm code at their extremes
  task automatic test_register_extremes();
    settle_results();
    write_register(atrf_pkg::CFG_WRITE_PERIOD, '0);
    write_register(atrf_pkg::CFG_ALARM_CODE, 32'd7);
    send_examine(8'd1, 8'h00, 3'd7, 48'd100);
    send_examine(8'd1, 8'h00, 3'd7, 48'd100);
    send_examine(8'd1, 8'h00, 3'd6, 48'd100);
    send_examine(8'd1, 8'h00, 3'd7, 48'd50);
    send_examine(8'd1, 8'h00, 3'd7, 48'd100);
    settle_results();
    write_register(atrf_pkg::CFG_WRITE_PERIOD, 32'hFFFF_FFFF);
    write_register(atrf_pkg::CFG_ALARM_CODE, 32'd3);
    send_examine(8'd2, 8'h00, 3'd3, TIME_MAX);
    send_examine(8'd2, 8'h00, 3'd4, TIME_MAX);
    send_examine(8'd3, 8'h00, 3'd3, 48'd0);
    send_examine(8'd3, 8'h00, 3'd5, 48'hFFFF_FFFF);
    send_examine(8'd3, 8'h00, 3'd6, 48'h3_0000_0000);
    send_clear();
  endtask

  // Phases of random traffic over a small pool of sources per setting
  task automatic test_random_traffic();
    logic [SRC_W-1:0]     pool[8];
    logic [TIME_BITS-1:0] clock_now;
    logic [PERIOD_W-1:0]  period_pick;
    longint unsigned      step;
    int                   pool_size;
    logic [SRC_W-1:0]     src;
    logic [STATUS_W-1:0]  status;
    logic [LEVEL_W-1:0]   level;
    for (int phase = 0; phase < 8; phase++) begin
      settle_results();
      case ($urandom_range(0, 5))
        0:       period_pick = '0;
        1:       period_pick = $urandom_range(1, 16);
        2:       period_pick = $urandom_range(100, 5000);
        3:       period_pick = $urandom;
        4:       period_pick = 32'hFFFF_FFFF - $urandom_range(0, 1000);
        default: period_pick = atrf_pkg::PERIOD_RESET;
      endcase
      write_register(atrf_pkg::CFG_WRITE_PERIOD, period_pick);
      write_register(atrf_pkg::CFG_ALARM_CODE, $urandom);
      no_idle   = (phase % 3 == 2);
      pool_size = $urandom_range(2, 8);
      for (int i = 0; i < 8; i++) pool[i] = SRC_W'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
        0:       clock_now = TIME_BITS'($urandom_range(0, 2000));
        1:       clock_now = TIME_BITS'({$urandom, $urandom});
        default: clock_now = TIME_MAX - TIME_BITS'($urandom_range(0, 100000));
      endcase
      for (int n = 0; n < 48; n++) begin
        if ($urandom_range(0, 49) == 0) begin
          send_clear();
        end else begin
          // advance time by a fraction of a period, now and then by several
          step = (longint'(period_cfg) * $urandom_range(0, 60)) / 100
                 + $urandom_range(0, 2);
          if ($urandom_range(0, 19) == 0)
            step = 3 * longint'(period_cfg) + $urandom_range(0, 5);
          clock_now = clock_now + step[TIME_BITS-1:0];
          src    = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_size - 1)]
                                                : SRC_W'($urandom_range(0, 255));
          status = ($urandom_range(0, 9) == 0) ? STATUS_W'($urandom_range(1, 255)) : '0;
          level  = ($urandom_range(0, 1) == 0) ? alarm_cfg : LEVEL_W'($urandom_range(0, 7));
          send_examine(src, status, level, clock_now);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // Check each result transfer against the oldest verdict; stall at random
  initial begin : result_monitor
    verdict_t want;
    int       stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result pass=%0b with nothing pending", pass));
        end else begin
          want = verdict_q.pop_front();
          if (pass !== want.fwd)
            report_mismatch($sformatf("event %0d: pass=%0b, predicted %0b",
                                      want.seq, pass, want.fwd));
        end
        stall = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= atrf_pkg::CFG_WRITE_PERIOD;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    func         <= FUNC_EXAMINE;
    source_id    <= '0;
    event_status <= '0;
    alarm_in     <= '0;
    event_time   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    settle_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/atrf_pkg.sv
hdl/atrf_ctrl.sv
hdl/atrf_datapath.sv
hdl/alarm_transition_rate_filter_core.sv
bench/tb_alarm_transition_rate_filter_core.sv
